>>> src/mtfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfe_pkg: shared types and constants of the move-to-front encoder
// Alphabet size, field widths and the item record that travels down the
// chain of list cells.
// ----------------------------------------------------------------------------
package mtfe_pkg;

	localparam int MTF_N  = 256;
	localparam int SYM_W  = 8;
	localparam int RANK_W = 8;

	// item record handed from one cell to the next
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              found;
		logic [SYM_W-1:0]  sym;
		logic [SYM_W-1:0]  carry;
		logic [RANK_W-1:0] rank;
	} mtfe_link_t;

endpackage

>>> src/mtfe_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfe_cell: one entry of the recency list
// Holds a single list entry. An item passing through compares its symbol
// against the entry, takes the displaced value from the cell in front and
// hands its own entry to the cell behind until the symbol is found.
// ----------------------------------------------------------------------------
module mtfe_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [mtfe_pkg::SYM_W-1:0]   idx,
	input  mtfe_pkg::mtfe_link_t         link_i,
	output mtfe_pkg::mtfe_link_t         link_o,
	output logic [mtfe_pkg::SYM_W-1:0]   entry
);
	import mtfe_pkg::*;

	logic [SYM_W-1:0] entry_q;
	logic [SYM_W-1:0] entry_d;
	logic             hit;
	mtfe_link_t       link_d;
	mtfe_link_t       link_q;

	// compare, record the rank and pass the displaced entry on
	always_comb begin
		hit    = link_i.valid && !link_i.found && (entry_q == link_i.sym);
		link_d = link_i;
		if (hit) begin
			link_d.found = 1'b1;
			link_d.rank  = RANK_W'(idx);
		end
		if (!link_i.found) begin
			link_d.carry = entry_q;
		end
	end

	// next entry: identity after the last item of a block, else shift in
	always_comb begin
		if (link_i.last) begin
			entry_d = idx;
		end else if (!link_i.found) begin
			entry_d = link_i.carry;
		end else begin
			entry_d = entry_q;
		end
	end

	// advance the item and update the entry as the chain moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= '0;
			entry_q <= idx;
		end else if (adv) begin
			link_q <= link_d;
			if (link_i.valid) begin
				entry_q <= entry_d;
			end
		end
	end

	assign link_o = link_q;
	assign entry  = entry_q;

endmodule

>>> src/move_to_front_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_encoder_core: byte move-to-front encoder
// Input channel: symbol, block_end with symbol_valid / symbol_stall.
// Output channel: rank, block_end_out with rank_valid / rank_stall.
// Every item gives one result: the rank of its symbol in the recency list
// before the move, plus a copy of block_end.
// The list lives in a chain of MTF_N cells, one entry each. An item enters
// cell 0 and walks one cell per cycle while the chain advances, so items
// follow each other in consecutive cycles; one item per cycle is accepted
// when the output flows. The result is registered in every cell and leaves
// the last cell of the chain.
// After the last item of a block each cell loads its own index as it passes,
// so the next item already sees the identity order.
// Reset loads the identity order into all cells at once and empties the chain;
// the first item is accepted in the first cycle after reset.
// While rank_valid is high and rank_stall is high the whole chain holds and
// symbol_stall is raised.
// ----------------------------------------------------------------------------
module move_to_front_encoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          symbol_valid,
	output logic                          symbol_stall,
	input  logic [mtfe_pkg::SYM_W-1:0]    symbol,
	input  logic                          block_end,
	output logic                          rank_valid,
	input  logic                          rank_stall,
	output logic [mtfe_pkg::RANK_W-1:0]   rank,
	output logic                          block_end_out
);
	import mtfe_pkg::*;

	mtfe_link_t       link [MTF_N+1];
	logic [SYM_W-1:0] entry [MTF_N];
	logic             adv;
	logic             out_of_range;

	// move the chain unless a finished result is held back
	assign adv          = !(rank_valid && rank_stall);
	assign symbol_stall = !adv;

	// build the item record entering cell 0
	assign out_of_range = ({1'b0, symbol} >= (SYM_W+1)'(MTF_N));
	always_comb begin
		link[0].valid = symbol_valid;
		link[0].last  = block_end;
		link[0].found = out_of_range;
		link[0].sym   = symbol;
		link[0].carry = symbol;
		link[0].rank  = RANK_W'(MTF_N - 1);
	end

	// chain of list cells
	for (genvar i = 0; i < MTF_N; i++) begin : g_cell
		mtfe_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.idx    (SYM_W'(i)),
			.link_i (link[i]),
			.link_o (link[i+1]),
			.entry  (entry[i])
		);
	end

	// results leave the last cell
	assign rank_valid    = link[MTF_N].valid;
	assign rank          = link[MTF_N].rank;
	assign block_end_out = link[MTF_N].last;

	// a stalled result holds still
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(rank_valid && rank_stall)
		|=> rank_valid && $stable(rank) && $stable(block_end_out))
		else $error("stalled result changed");

	// an accepted symbol lands at the front of the list
	a_move_front: assert property (@(posedge clk) disable iff (!arst_n)
		(symbol_valid && !symbol_stall && !block_end && !out_of_range)
		|=> (entry[0] == $past(symbol)))
		else $error("accepted symbol not moved to front");

	// the last item of a block restores identity at the front
	a_block_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(symbol_valid && !symbol_stall && block_end)
		|=> (entry[0] == '0))
		else $error("list not restored after block end");

endmodule
